@@ sv/cdcs_pkg.sv @@
// Package for the cable distance constraint solver: fixed-point constants,
// pipeline stage indices, the word structs and the arithmetic step functions.
// Depends on nothing; every other file of the block uses it by scoped names.
`timescale 1ns / 1ps

package cdcs_pkg;

    localparam int FRAC_BITS = 16;
    localparam int QW        = FRAC_BITS + 1;   // ratio and direction quotients
    localparam int RT_STEPS  = 32;              // root bits of a 64-bit radicand

    // Back pipeline stage indices
    localparam int ST_MAG  = 0;
    localparam int ST_SQR  = 1;
    localparam int ST_SUM  = 2;
    localparam int ST_RT0  = 3;
    localparam int ST_DIST = ST_RT0 + RT_STEPS;
    localparam int ST_DV0  = ST_DIST + 1;
    localparam int ST_M1   = ST_DV0 + QW;
    localparam int ST_M2   = ST_M1 + 1;
    localparam int ST_OUT  = ST_M2 + 1;
    localparam int N_STG   = ST_OUT + 1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    localparam logic [QW:0] Q_ONE = (QW + 1)'(1) << FRAC_BITS;

    // Configuration register indices
    localparam logic [2:0] REG_CABLE_LENGTH = 3'd0;
    localparam logic [2:0] REG_OFF_A_X      = 3'd1;
    localparam logic [2:0] REG_OFF_A_Y      = 3'd2;
    localparam logic [2:0] REG_OFF_B_X      = 3'd3;
    localparam logic [2:0] REG_OFF_B_Y      = 3'd4;
    localparam logic [2:0] REG_ATTACHED_A   = 3'd5;
    localparam logic [2:0] REG_ATTACHED_B   = 3'd6;

    typedef struct packed {
        logic        [30:0] cable_length;
        logic signed [31:0] off_ax;
        logic signed [31:0] off_ay;
        logic signed [31:0] off_bx;
        logic signed [31:0] off_by;
        logic               att_a;
        logic               att_b;
    } t_cfg;

    typedef struct packed {
        logic signed [31:0] pax;
        logic signed [31:0] pay;
        logic signed [31:0] pbx;
        logic signed [31:0] pby;
        logic signed [33:0] dx;
        logic signed [33:0] dy;
        logic        [30:0] ma;
        logic        [30:0] mb;
    } t_item;

    typedef struct packed {
        logic signed [31:0] pax;
        logic signed [31:0] pay;
        logic signed [31:0] pbx;
        logic signed [31:0] pby;
        logic               nx;
        logic               px;
        logic               ny;
        logic               py;
        logic        [30:0] ma;
        logic        [30:0] mb;
        logic        [31:0] msum;
        logic               degen;
        logic        [30:0] ux;
        logic        [30:0] uy;
        logic        [1:0]  sh;
        logic        [61:0] sqx;
        logic        [61:0] sqy;
        logic        [62:0] rad;
        logic        [33:0] rt_rem;
        logic        [31:0] rt;
        logic        [31:0] fa_rem;
        logic        [31:0] fb_rem;
        logic        [QW-1:0] fa;
        logic        [QW-1:0] fb;
        logic               viol;
        logic        [34:0] e;
        logic        [31:0] ux_rem;
        logic        [31:0] uy_rem;
        logic        [QW-1:0] udx;
        logic        [QW-1:0] udy;
        logic        [34:0] pa;
        logic        [34:0] pb;
        logic        [34:0] mvax;
        logic        [34:0] mvay;
        logic        [34:0] mvbx;
        logic        [34:0] mvby;
        logic signed [31:0] nax;
        logic signed [31:0] nay;
        logic signed [31:0] nbx;
        logic signed [31:0] nby;
    } t_bk;

    // One restoring division step: returns {quotient bit, new remainder}.
    function automatic logic [32:0] div_step(input logic [31:0] rem,
                                             input logic [31:0] dvs,
                                             input logic        b);
        logic [32:0] t;
        logic [32:0] d;
        t = {rem, b};
        d = t - {1'b0, dvs};
        if (t >= {1'b0, dvs}) begin
            return {1'b1, d[31:0]};
        end
        return {1'b0, t[31:0]};
    endfunction

    // One digit of the square root: returns {new remainder, new root}.
    function automatic logic [65:0] sqrt_step(input logic [33:0] rem,
                                              input logic [31:0] root,
                                              input logic [1:0]  b);
        logic [35:0] trial;
        logic [35:0] t;
        logic [35:0] d;
        trial = {rem, b};
        t     = {2'b00, root, 2'b01};
        d     = trial - t;
        if (trial >= t) begin
            return {d[33:0], root[30:0], 1'b1};
        end
        return {trial[33:0], root[30:0], 1'b0};
    endfunction

    // Adds a signed move of the given magnitude and saturates to 32 bits.
    function automatic logic signed [31:0] move_sat(input logic signed [31:0] pos,
                                                    input logic        [34:0] mv,
                                                    input logic               neg);
        logic signed [36:0] m;
        logic signed [36:0] v;
        m = neg ? -$signed({2'b00, mv}) : $signed({2'b00, mv});
        v = {{5{pos[31]}}, pos} + m;
        if (v[36:31] == {6{v[31]}}) begin
            return v[31:0];
        end
        return v[36] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    endfunction

endpackage

@@ sv/cdcs_front.sv @@
// Front part: accepts input words, forms the anchors and their differences
// and masks the masses of detached bodies. Uses cdcs_pkg.
`timescale 1ns / 1ps

module cdcs_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cdcs_pkg::t_cfg     i_cfg,
    input  logic               i_valid,
    input  logic [191:0]       i_data,
    output logic               o_ready,
    output logic               o_valid,
    output cdcs_pkg::t_item    o_item,
    input  logic               i_ready
);

    logic            r_vld;
    cdcs_pkg::t_item r_item;
    cdcs_pkg::t_item n_item;
    logic signed [32:0] aax, aay, abx, aby;

    assign o_ready = !r_vld || i_ready;

    always_comb begin
        n_item.pax = i_data[31:0];
        n_item.pay = i_data[63:32];
        n_item.pbx = i_data[95:64];
        n_item.pby = i_data[127:96];
        n_item.ma  = i_cfg.att_a ? i_data[158:128] : 31'd0;
        n_item.mb  = i_cfg.att_b ? i_data[189:159] : 31'd0;
        aax = {n_item.pax[31], n_item.pax};
        aay = {n_item.pay[31], n_item.pay};
        abx = {n_item.pbx[31], n_item.pbx};
        aby = {n_item.pby[31], n_item.pby};
        if (i_cfg.att_a) begin
            aax = aax + {i_cfg.off_ax[31], i_cfg.off_ax};
            aay = aay + {i_cfg.off_ay[31], i_cfg.off_ay};
        end
        if (i_cfg.att_b) begin
            abx = abx + {i_cfg.off_bx[31], i_cfg.off_bx};
            aby = aby + {i_cfg.off_by[31], i_cfg.off_by};
        end
        n_item.dx = {abx[32], abx} - {aax[32], aax};
        n_item.dy = {aby[32], aby} - {aay[32], aay};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_vld;
    assign o_item  = r_item;

endmodule

@@ sv/cdcs_fifo.sv @@
// Short queue of item words between the front and back parts.
// Uses cdcs_pkg for the word type and depth.
`timescale 1ns / 1ps

module cdcs_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cdcs_pkg::t_item i_item,
    output logic            o_ready,
    output logic            o_valid,
    output cdcs_pkg::t_item o_item,
    input  logic            i_pop
);

    cdcs_pkg::t_item                r_mem [cdcs_pkg::FIFO_DEPTH];
    logic [cdcs_pkg::FIFO_AW-1:0]   r_wp;
    logic [cdcs_pkg::FIFO_AW-1:0]   r_rp;
    logic [cdcs_pkg::FIFO_AW:0]     r_cnt;
    logic                           push;
    logic                           pop;

    assign o_ready = (r_cnt != (cdcs_pkg::FIFO_AW + 1)'(cdcs_pkg::FIFO_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign push    = i_push && o_ready;
    assign pop     = i_pop && o_valid;
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (push) begin
            r_mem[r_wp] <= i_item;
        end
    end

endmodule

@@ sv/cdcs_back.sv @@
// Back part: pipelined magnitude, square root, dividers, multipliers and
// saturation; its last stage is the output register. Uses cdcs_pkg.
`timescale 1ns / 1ps

module cdcs_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [30:0]       i_cable_length,
    input  logic              i_valid,
    input  cdcs_pkg::t_item   i_item,
    output logic              o_ready,
    output logic              o_valid,
    output cdcs_pkg::t_bk     o_res,
    input  logic              i_ready
);

    cdcs_pkg::t_bk                 r_stg [cdcs_pkg::N_STG];
    cdcs_pkg::t_bk                 n_stg [cdcs_pkg::N_STG];
    logic [cdcs_pkg::N_STG-1:0]    r_vld;
    logic                          en;

    assign en      = !r_vld[cdcs_pkg::N_STG-1] || i_ready;
    assign o_ready = en;
    assign o_valid = r_vld[cdcs_pkg::N_STG-1];
    assign o_res   = r_stg[cdcs_pkg::ST_OUT];

    for (genvar k = 0; k < cdcs_pkg::N_STG; k++) begin : g_stg
        if (k == cdcs_pkg::ST_MAG) begin : g_mag
            always_comb begin
                logic [33:0] adx;
                logic [33:0] ady;
                logic [33:0] big;
                n_stg[k]      = r_stg[k];
                n_stg[k].pax  = i_item.pax;
                n_stg[k].pay  = i_item.pay;
                n_stg[k].pbx  = i_item.pbx;
                n_stg[k].pby  = i_item.pby;
                n_stg[k].ma   = i_item.ma;
                n_stg[k].mb   = i_item.mb;
                n_stg[k].nx   = i_item.dx[33];
                n_stg[k].px   = !i_item.dx[33] && (i_item.dx != '0);
                n_stg[k].ny   = i_item.dy[33];
                n_stg[k].py   = !i_item.dy[33] && (i_item.dy != '0);
                adx = i_item.dx[33] ? 34'(-i_item.dx) : 34'(i_item.dx);
                ady = i_item.dy[33] ? 34'(-i_item.dy) : 34'(i_item.dy);
                big = (adx > ady) ? adx : ady;
                n_stg[k].sh   = big[33] ? 2'd3 : big[32] ? 2'd2 : big[31] ? 2'd1 : 2'd0;
                n_stg[k].ux   = 31'(adx >> n_stg[k].sh);
                n_stg[k].uy   = 31'(ady >> n_stg[k].sh);
                n_stg[k].msum = {1'b0, i_item.ma} + {1'b0, i_item.mb};
                n_stg[k].degen = (n_stg[k].msum == '0);
            end
        end else if (k == cdcs_pkg::ST_SQR) begin : g_sqr
            always_comb begin
                n_stg[k]     = r_stg[k-1];
                n_stg[k].sqx = r_stg[k-1].ux * r_stg[k-1].ux;
                n_stg[k].sqy = r_stg[k-1].uy * r_stg[k-1].uy;
            end
        end else if (k == cdcs_pkg::ST_SUM) begin : g_sum
            always_comb begin
                n_stg[k]        = r_stg[k-1];
                n_stg[k].rad    = {1'b0, r_stg[k-1].sqx} + {1'b0, r_stg[k-1].sqy};
                n_stg[k].rt_rem = '0;
                n_stg[k].rt     = '0;
                n_stg[k].fa_rem = 32'(r_stg[k-1].ma >> 1);
                n_stg[k].fb_rem = 32'(r_stg[k-1].mb >> 1);
                n_stg[k].fa     = '0;
                n_stg[k].fb     = '0;
            end
        end else if (k < cdcs_pkg::ST_DIST) begin : g_rt
            localparam int I = k - cdcs_pkg::ST_RT0;
            always_comb begin
                logic [63:0] rad64;
                logic [65:0] sq;
                logic [32:0] qa;
                logic [32:0] qb;
                n_stg[k] = r_stg[k-1];
                rad64 = {1'b0, r_stg[k-1].rad};
                sq = cdcs_pkg::sqrt_step(r_stg[k-1].rt_rem, r_stg[k-1].rt,
                                         rad64[63-2*I -: 2]);
                n_stg[k].rt_rem = sq[65:32];
                n_stg[k].rt     = sq[31:0];
                // The mass ratios are divided alongside the root.
                if (I < cdcs_pkg::QW) begin
                    qa = cdcs_pkg::div_step(r_stg[k-1].fa_rem, r_stg[k-1].msum,
                                            (I == 0) ? r_stg[k-1].ma[0] : 1'b0);
                    qb = cdcs_pkg::div_step(r_stg[k-1].fb_rem, r_stg[k-1].msum,
                                            (I == 0) ? r_stg[k-1].mb[0] : 1'b0);
                    n_stg[k].fa_rem = qa[31:0];
                    n_stg[k].fb_rem = qb[31:0];
                    n_stg[k].fa     = {r_stg[k-1].fa[cdcs_pkg::QW-2:0], qa[32]};
                    n_stg[k].fb     = {r_stg[k-1].fb[cdcs_pkg::QW-2:0], qb[32]};
                end
            end
        end else if (k == cdcs_pkg::ST_DIST) begin : g_dist
            always_comb begin
                logic [34:0] span;
                n_stg[k]        = r_stg[k-1];
                span            = 35'(r_stg[k-1].rt) << r_stg[k-1].sh;
                n_stg[k].viol   = span > {4'b0, i_cable_length};
                n_stg[k].e      = span - {4'b0, i_cable_length};
                n_stg[k].ux_rem = 32'(r_stg[k-1].ux >> 1);
                n_stg[k].uy_rem = 32'(r_stg[k-1].uy >> 1);
                n_stg[k].udx    = '0;
                n_stg[k].udy    = '0;
            end
        end else if (k < cdcs_pkg::ST_M1) begin : g_dv
            localparam int J = k - cdcs_pkg::ST_DV0;
            always_comb begin
                logic [32:0] qx;
                logic [32:0] qy;
                n_stg[k] = r_stg[k-1];
                qx = cdcs_pkg::div_step(r_stg[k-1].ux_rem, r_stg[k-1].rt,
                                        (J == 0) ? r_stg[k-1].ux[0] : 1'b0);
                qy = cdcs_pkg::div_step(r_stg[k-1].uy_rem, r_stg[k-1].rt,
                                        (J == 0) ? r_stg[k-1].uy[0] : 1'b0);
                n_stg[k].ux_rem = qx[31:0];
                n_stg[k].uy_rem = qy[31:0];
                n_stg[k].udx    = {r_stg[k-1].udx[cdcs_pkg::QW-2:0], qx[32]};
                n_stg[k].udy    = {r_stg[k-1].udy[cdcs_pkg::QW-2:0], qy[32]};
            end
        end else if (k == cdcs_pkg::ST_M1) begin : g_m1
            always_comb begin
                logic [34+cdcs_pkg::QW:0] pra;
                logic [34+cdcs_pkg::QW:0] prb;
                n_stg[k]    = r_stg[k-1];
                pra         = r_stg[k-1].e * r_stg[k-1].fa;
                prb         = r_stg[k-1].e * r_stg[k-1].fb;
                n_stg[k].pa = 35'(pra >> cdcs_pkg::FRAC_BITS);
                n_stg[k].pb = 35'(prb >> cdcs_pkg::FRAC_BITS);
            end
        end else if (k == cdcs_pkg::ST_M2) begin : g_m2
            always_comb begin
                logic [34+cdcs_pkg::QW:0] p0, p1, p2, p3;
                n_stg[k]      = r_stg[k-1];
                p0            = r_stg[k-1].pa * r_stg[k-1].udx;
                p1            = r_stg[k-1].pa * r_stg[k-1].udy;
                p2            = r_stg[k-1].pb * r_stg[k-1].udx;
                p3            = r_stg[k-1].pb * r_stg[k-1].udy;
                n_stg[k].mvax = 35'(p0 >> cdcs_pkg::FRAC_BITS);
                n_stg[k].mvay = 35'(p1 >> cdcs_pkg::FRAC_BITS);
                n_stg[k].mvbx = 35'(p2 >> cdcs_pkg::FRAC_BITS);
                n_stg[k].mvby = 35'(p3 >> cdcs_pkg::FRAC_BITS);
            end
        end else begin : g_out
            always_comb begin
                cdcs_pkg::t_bk s;
                s = r_stg[k-1];
                n_stg[k] = s;
                if (s.viol && !s.degen) begin
                    n_stg[k].nax = cdcs_pkg::move_sat(s.pax, s.mvax, s.nx);
                    n_stg[k].nay = cdcs_pkg::move_sat(s.pay, s.mvay, s.ny);
                    n_stg[k].nbx = cdcs_pkg::move_sat(s.pbx, s.mvbx, s.px);
                    n_stg[k].nby = cdcs_pkg::move_sat(s.pby, s.mvby, s.py);
                end else begin
                    n_stg[k].nax = s.pax;
                    n_stg[k].nay = s.pay;
                    n_stg[k].nbx = s.pbx;
                    n_stg[k].nby = s.pby;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_stg[k] <= n_stg[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[cdcs_pkg::N_STG-2:0], i_valid};
        end
    end

    // Without a correction the positions leave unchanged.
    a_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[cdcs_pkg::ST_OUT] && (r_stg[cdcs_pkg::ST_OUT].degen ||
                                     !r_stg[cdcs_pkg::ST_OUT].viol)) |->
        (r_stg[cdcs_pkg::ST_OUT].nax == r_stg[cdcs_pkg::ST_OUT].pax &&
         r_stg[cdcs_pkg::ST_OUT].nby == r_stg[cdcs_pkg::ST_OUT].pby))
        else $error("positions changed without a correction");

    // A violation needs a nonzero distance, so the direction divide is safe.
    a_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[cdcs_pkg::ST_OUT] && r_stg[cdcs_pkg::ST_OUT].viol) |->
        (r_stg[cdcs_pkg::ST_OUT].rt != '0))
        else $error("violation reported at zero distance");

    // The two mass shares sum to one, less at most one unit of rounding.
    a_ratio: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[cdcs_pkg::ST_M1] && !r_stg[cdcs_pkg::ST_M1].degen) |->
        (({1'b0, r_stg[cdcs_pkg::ST_M1].fa} + {1'b0, r_stg[cdcs_pkg::ST_M1].fb}
              <= cdcs_pkg::Q_ONE) &&
         ({1'b0, r_stg[cdcs_pkg::ST_M1].fa} + {1'b0, r_stg[cdcs_pkg::ST_M1].fb}
              >= cdcs_pkg::Q_ONE - 1'b1)))
        else $error("mass shares do not sum to one");

endmodule

@@ sv/cable_distance_constraint_solver.sv @@
// Top level of the cable distance constraint solver: configuration
// registers and the front part, queue and back pipeline. Uses cdcs_pkg.
`timescale 1ns / 1ps

// The block takes one joint per word on the slave stream: the positions of
// bodies A and B and their masses, all in Q16.16. For each word it returns
// one word on the master stream with the corrected positions, saturated to
// 32 bits, and two status flags in tuser: violated (anchor distance above
// the cable length) and degenerate (no attached mass, positions unchanged).
// Cable length, anchor offsets and the attached flags are written through
// the plain configuration port; the user must write them only while no
// word is in flight, as the block does not enforce it. Throughput is one
// word per clock while the receiver does not stall. A word passes one front
// register, the queue and a 56-stage back pipeline, of which the 32-step
// square root and the 17-step direction divide make up most; the mass
// ratio divide runs beside the root. When the receiver stalls, the whole
// back pipeline holds with its result steady, the four-word queue fills and
// then the slave tready falls. Reset clears all valid state and loads the
// register defaults: cable length 1.0, zero offsets, both bodies detached.

module cable_distance_constraint_solver (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // configuration port
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [31:0]   i_cfg_data,
    // slave stream
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    // fields from bit 0: pos_a_x, pos_a_y, pos_b_x, pos_b_y, mass_a, mass_b, pad
    input  logic [191:0]  i_s_tdata,
    // master stream
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    // fields from bit 0: new_pos_a_x, new_pos_a_y, new_pos_b_x, new_pos_b_y
    output logic [127:0]  o_m_tdata,
    // fields from bit 0: violated, degenerate
    output logic [1:0]    o_m_tuser
);

    cdcs_pkg::t_cfg   r_cfg;
    cdcs_pkg::t_item  fr_item;
    cdcs_pkg::t_item  q_item;
    cdcs_pkg::t_bk    bk_res;
    logic             fr_valid;
    logic             q_ready;
    logic             q_valid;
    logic             bk_ready;

    // Configuration registers; indices beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cable_length <= 31'd65536;
            r_cfg.off_ax       <= '0;
            r_cfg.off_ay       <= '0;
            r_cfg.off_bx       <= '0;
            r_cfg.off_by       <= '0;
            r_cfg.att_a        <= 1'b0;
            r_cfg.att_b        <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                cdcs_pkg::REG_CABLE_LENGTH: r_cfg.cable_length <= i_cfg_data[30:0];
                cdcs_pkg::REG_OFF_A_X:      r_cfg.off_ax       <= i_cfg_data;
                cdcs_pkg::REG_OFF_A_Y:      r_cfg.off_ay       <= i_cfg_data;
                cdcs_pkg::REG_OFF_B_X:      r_cfg.off_bx       <= i_cfg_data;
                cdcs_pkg::REG_OFF_B_Y:      r_cfg.off_by       <= i_cfg_data;
                cdcs_pkg::REG_ATTACHED_A:   r_cfg.att_a        <= i_cfg_data[0];
                cdcs_pkg::REG_ATTACHED_B:   r_cfg.att_b        <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // The front part forms anchors and differences in one registered step.
    cdcs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (i_s_tvalid),
        .i_data  (i_s_tdata),
        .o_ready (o_s_tready),
        .o_valid (fr_valid),
        .o_item  (fr_item),
        .i_ready (q_ready)
    );

    // The queue lets the front keep accepting while the back is held.
    cdcs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_valid),
        .i_item  (fr_item),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (bk_ready)
    );

    // The back pipeline does the root, divides and multiplies.
    cdcs_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cable_length (r_cfg.cable_length),
        .i_valid        (q_valid),
        .i_item         (q_item),
        .o_ready        (bk_ready),
        .o_valid        (o_m_tvalid),
        .o_res          (bk_res),
        .i_ready        (i_m_tready)
    );

    assign o_m_tdata = {bk_res.nby, bk_res.nbx, bk_res.nay, bk_res.nax};
    assign o_m_tuser = {bk_res.degen, bk_res.viol};

endmodule
